### sv/dcc_pkg.sv
// Types and constants shared by the DCC baseline packet generator.
package dcc_pkg;

    localparam logic [1:0] MODE_THROTTLE = 2'd0;
    localparam logic [1:0] MODE_ESTOP    = 2'd1;
    localparam logic [1:0] MODE_PROBE    = 2'd2;

    localparam logic [1:0] CFG_ONE_PERIOD    = 2'd0;
    localparam logic [1:0] CFG_ZERO_PERIOD   = 2'd1;
    localparam logic [1:0] CFG_REVERSE_LIMIT = 2'd2;
    localparam logic [1:0] CFG_FORWARD_START = 2'd3;

    localparam logic [7:0] ONE_PERIOD_RESET    = 8'd56;
    localparam logic [7:0] ZERO_PERIOD_RESET   = 8'd112;
    localparam logic [9:0] REVERSE_LIMIT_RESET = 10'd255;
    localparam logic [9:0] FORWARD_START_RESET = 10'd769;

    localparam logic [7:0] DATA_SPEED_BASE = 8'b0100_0000;
    localparam logic [7:0] DATA_DIR_FWD    = 8'b0010_0000;
    localparam logic [7:0] DATA_ESTOP      = 8'b0110_0001;
    localparam logic [7:0] DATA_PROBE      = 8'b0111_1110;
    localparam logic [7:0] ESTOP_ADDRESS   = 8'd0;

    // Start bit, address, separator, data, separator, error byte, end bit.
    localparam int TAIL_BITS = 28;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] target_address;
        logic [9:0] throttle;
    } t_in_item;

    typedef struct packed {
        logic       line_bit;
        logic [7:0] period_ticks;
        logic [6:0] high_ticks;
        logic       last_bit;
    } t_out_item;

endpackage

### sv/dcc_baseline_packet_generator.sv
// DCC baseline packet generator: builds one packet per request and sends it bit by bit.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_stall   t_in_item  (mode, address, throttle)
//   out       output     o_out_valid / i_out_stall t_out_item (bit, period, mark, last)
//   cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// A packet is PREAMBLE_BITS + 28 output items, 41 at the default, one per cycle while
// out is not stalled; the bit serializer emits them in order.
// One request is held in a pending buffer while the previous packet is sent, so
// packets follow each other without a gap. A mode 3 request is taken and dropped.
// Reset is synchronous and clears the control state and the registers to defaults.
// A stall on out holds the output register and pauses the serializer.
module dcc_baseline_packet_generator #(
    parameter int PREAMBLE_BITS = 13
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dcc_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dcc_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [9:0]          i_cfg_data
);
    import dcc_pkg::*;

    localparam int FRAME_BITS = PREAMBLE_BITS + TAIL_BITS;
    localparam int CW         = $clog2(FRAME_BITS);
    localparam logic [CW-1:0] LAST_POS = CW'(FRAME_BITS - 1);
    localparam logic [CW-1:0] PRE_POS  = CW'(PREAMBLE_BITS);

    logic [7:0] r_one_period, r_zero_period;
    logic [9:0] r_reverse_limit, r_forward_start;
    logic       r_direction, n_direction;

    logic       r_pend_valid, n_pend_valid;
    logic [7:0] r_pend_addr, n_pend_addr;
    logic [7:0] r_pend_data, n_pend_data;

    logic                 r_busy, n_busy;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [TAIL_BITS-1:0] r_tail, n_tail;

    logic       r_out_valid, n_out_valid;
    t_out_item  r_out_item, n_out_item;

    logic       in_accept, out_free, advance, finish, load;
    logic [9:0] mag;
    logic [3:0] speed;
    logic [7:0] req_addr, req_data;
    logic       req_ok, cur_bit;
    logic [7:0] cur_period;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign advance   = r_busy && out_free;
    assign finish    = advance && (r_cnt == LAST_POS);
    assign load      = r_pend_valid && (!r_busy || finish);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_period    <= ONE_PERIOD_RESET;
            r_zero_period   <= ZERO_PERIOD_RESET;
            r_reverse_limit <= REVERSE_LIMIT_RESET;
            r_forward_start <= FORWARD_START_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ONE_PERIOD:    r_one_period    <= i_cfg_data[7:0];
                CFG_ZERO_PERIOD:   r_zero_period   <= i_cfg_data[7:0];
                CFG_REVERSE_LIMIT: r_reverse_limit <= i_cfg_data;
                CFG_FORWARD_START: r_forward_start <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request decode: the packet's address and data byte.
    always_comb begin
        n_direction = r_direction;
        mag         = 10'd0;
        req_ok      = 1'b1;
        req_addr    = i_in_item.target_address;
        req_data    = DATA_PROBE;
        if (i_in_item.throttle <= r_reverse_limit) begin
            mag = r_reverse_limit - i_in_item.throttle;
        end else if (i_in_item.throttle >= r_forward_start) begin
            mag = i_in_item.throttle - r_forward_start;
        end
        // Saturate at 255, then keep the top nibble.
        speed = (|mag[9:8]) ? 4'hF : mag[7:4];
        case (i_in_item.mode)
            MODE_THROTTLE: begin
                if (i_in_item.throttle <= r_reverse_limit) begin
                    n_direction = 1'b0;
                end else if (i_in_item.throttle >= r_forward_start) begin
                    n_direction = 1'b1;
                end
                req_data = DATA_SPEED_BASE | (n_direction ? DATA_DIR_FWD : 8'd0)
                         | {4'd0, speed};
            end
            MODE_ESTOP: begin
                req_addr = ESTOP_ADDRESS;
                req_data = DATA_ESTOP;
            end
            MODE_PROBE: begin
                req_data = DATA_PROBE;
            end
            default: req_ok = 1'b0;
        endcase
        if (!in_accept) begin
            n_direction = r_direction;
        end
    end

    // Pending buffer, serializer and output register.
    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_addr  = r_pend_addr;
        n_pend_data  = r_pend_data;
        n_busy       = r_busy;
        n_cnt        = r_cnt;
        n_tail       = r_tail;
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;

        cur_bit    = (r_cnt < PRE_POS) ? 1'b1 : r_tail[TAIL_BITS-1];
        cur_period = cur_bit ? r_one_period : r_zero_period;

        if (out_free) begin
            n_out_valid = advance;
        end
        if (advance) begin
            n_out_item.line_bit     = cur_bit;
            n_out_item.period_ticks = cur_period;
            n_out_item.high_ticks   = cur_period[7:1];
            n_out_item.last_bit     = (r_cnt == LAST_POS);
            n_cnt = r_cnt + CW'(1);
            if (r_cnt >= PRE_POS) begin
                n_tail = {r_tail[TAIL_BITS-2:0], 1'b0};
            end
            if (finish) begin
                n_busy = 1'b0;
                n_cnt  = '0;
            end
        end

        if (load) begin
            n_busy       = 1'b1;
            n_cnt        = '0;
            n_tail       = {1'b0, r_pend_addr, 1'b0, r_pend_data, 1'b0,
                            r_pend_addr ^ r_pend_data, 1'b1};
            n_pend_valid = 1'b0;
        end
        if (in_accept && req_ok) begin
            n_pend_valid = 1'b1;
            n_pend_addr  = req_addr;
            n_pend_data  = req_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_busy       <= 1'b0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_direction  <= n_direction;
            r_pend_valid <= n_pend_valid;
            r_busy       <= n_busy;
            r_cnt        <= n_cnt;
            r_out_valid  <= n_out_valid;
        end
        r_pend_addr <= n_pend_addr;
        r_pend_data <= n_pend_data;
        r_tail      <= n_tail;
        r_out_item  <= n_out_item;
    end

    assign o_in_stall  = r_pend_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == '0)
        else $error("serializer count not cleared while idle");

    a_pend_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid && !r_busy |=> r_busy)
        else $error("pending packet not started");

    a_end_bit_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last_bit |-> o_out_item.line_bit)
        else $error("end bit of a packet is not a one");

    a_preamble_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_cnt < PRE_POS |=> o_out_item.line_bit && !o_out_item.last_bit)
        else $error("preamble bit is not a one");

endmodule

### test/dcc_packet_checker.sv
// Checker for the DCC packet generator: predicts every serial bit and compares it.
module dcc_packet_checker #(
    parameter int PREAMBLE_BITS = 13
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  dcc_pkg::t_in_item   i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  dcc_pkg::t_out_item  i_out_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [9:0]          i_cfg_data,
    output int                  o_fail_count,
    output int                  o_bits_pending,
    output int                  o_bits_checked
);
    import dcc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [7:0] one_period_q;
    logic [7:0] zero_period_q;
    logic [9:0] reverse_limit_q;
    logic [9:0] forward_start_q;
    logic       forward_dir_q;

    dcc_pkg::t_out_item line_bits_q[$];
    int                 fail_count;
    int                 bits_checked;

    function automatic dcc_pkg::t_out_item line_cell(input logic b, input logic last);
        dcc_pkg::t_out_item bit_item;
        bit_item.line_bit     = b;
        bit_item.period_ticks = b ? one_period_q : zero_period_q;
        bit_item.high_ticks   = bit_item.period_ticks[7:1];
        bit_item.last_bit     = last;
        return bit_item;
    endfunction

    task automatic queue_byte(input logic [7:0] value);
        for (int s = 7; s >= 0; s--) begin
            line_bits_q.push_back(line_cell(value[s], 1'b0));
        end
    endtask

    // Builds the whole frame for one request and appends its bits; an unused mode adds none.
    task automatic queue_packet(input dcc_pkg::t_in_item req);
        logic [7:0] addr;
        logic [7:0] data;
        logic [9:0] magnitude;
        logic [7:0] clipped;
        magnitude = '0;
        case (req.mode)
            MODE_THROTTLE: begin
                // The reverse test comes first, so it wins when the ranges overlap.
                if (req.throttle <= reverse_limit_q) begin
                    forward_dir_q = 1'b0;
                    magnitude = reverse_limit_q - req.throttle;
                end else if (req.throttle >= forward_start_q) begin
                    forward_dir_q = 1'b1;
                    magnitude = req.throttle - forward_start_q;
                end
                clipped = (magnitude > 10'd255) ? 8'hFF : magnitude[7:0];
                addr = req.target_address;
                data = DATA_SPEED_BASE | (forward_dir_q ? DATA_DIR_FWD : 8'h00)
                       | {4'h0, clipped[7:4]};
            end
            MODE_ESTOP: begin
                addr = ESTOP_ADDRESS;
                data = DATA_ESTOP;
            end
            MODE_PROBE: begin
                addr = req.target_address;
                data = DATA_PROBE;
            end
            default: return;
        endcase
        for (int p = 0; p < PREAMBLE_BITS; p++) begin
            line_bits_q.push_back(line_cell(1'b1, 1'b0));
        end
        line_bits_q.push_back(line_cell(1'b0, 1'b0));
        queue_byte(addr);
        line_bits_q.push_back(line_cell(1'b0, 1'b0));
        queue_byte(data);
        line_bits_q.push_back(line_cell(1'b0, 1'b0));
        queue_byte(addr ^ data);
        line_bits_q.push_back(line_cell(1'b1, 1'b1));
    endtask

    task automatic check_bit(input dcc_pkg::t_out_item got);
        dcc_pkg::t_out_item want;
        if (line_bits_q.size() == 0) begin
            if (fail_count < REPORT_LIMIT) begin
                $display("unexpected bit %0d: line=%b period=%0d high=%0d last=%b",
                         bits_checked, got.line_bit, got.period_ticks, got.high_ticks,
                         got.last_bit);
            end
            fail_count++;
        end else begin
            want = line_bits_q.pop_front();
            if (got.line_bit !== want.line_bit || got.period_ticks !== want.period_ticks ||
                got.high_ticks !== want.high_ticks || got.last_bit !== want.last_bit) begin
                if (fail_count < REPORT_LIMIT) begin
                    $display("bit %0d mismatch: expected line=%b period=%0d high=%0d last=%b",
                             bits_checked, want.line_bit, want.period_ticks,
                             want.high_ticks, want.last_bit);
                    $display("                  actual   line=%b period=%0d high=%0d last=%b",
                             got.line_bit, got.period_ticks, got.high_ticks, got.last_bit);
                end
                fail_count++;
            end
        end
        bits_checked++;
    endtask

    initial begin
        fail_count   = 0;
        bits_checked = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            one_period_q    = ONE_PERIOD_RESET;
            zero_period_q   = ZERO_PERIOD_RESET;
            reverse_limit_q = REVERSE_LIMIT_RESET;
            forward_start_q = FORWARD_START_RESET;
            forward_dir_q   = 1'b0;
            line_bits_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ONE_PERIOD:    one_period_q    = i_cfg_data[7:0];
                    CFG_ZERO_PERIOD:   zero_period_q   = i_cfg_data[7:0];
                    CFG_REVERSE_LIMIT: reverse_limit_q = i_cfg_data;
                    CFG_FORWARD_START: forward_start_q = i_cfg_data;
                    default: ;
                endcase
            end
            // A bit leaving now cannot belong to a request taken at this same edge.
            if (i_out_valid && !i_out_stall) begin
                check_bit(i_out_item);
            end
            if (i_in_valid && !i_in_stall) begin
                queue_packet(i_in_item);
            end
        end
        o_fail_count   <= fail_count;
        o_bits_pending <= line_bits_q.size();
        o_bits_checked <= bits_checked;
    end

endmodule

### test/dcc_baseline_packet_generator_tb.sv
// Testbench top for the DCC packet generator: clock, reset, stimulus and verdict.
module dcc_baseline_packet_generator_tb;
    import dcc_pkg::*;

    localparam int PREAMBLE_BITS = 13;
    localparam int PACKET_BITS   = PREAMBLE_BITS + TAIL_BITS;
    localparam int DRAIN_CYCLES  = 2 * PACKET_BITS + 10;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_ITEMS  = 220;
    localparam int CHUNKS        = 5;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_item;
    logic               i_cfg_we    = 1'b0;
    logic [1:0]         i_cfg_index = CFG_ONE_PERIOD;
    logic [9:0]         i_cfg_data  = '0;

    int fail_count;
    int bits_pending;
    int bits_checked;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    logic [9:0] cur_reverse_limit = REVERSE_LIMIT_RESET;
    logic [9:0] cur_forward_start = FORWARD_START_RESET;
    int packet_count   = 0;
    int ignored_count  = 0;
    int settings_count = 0;

    dcc_baseline_packet_generator #(
        .PREAMBLE_BITS(PREAMBLE_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    dcc_packet_checker #(
        .PREAMBLE_BITS(PREAMBLE_BITS)
    ) checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_item      (i_in_item),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_item     (o_out_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_bits_pending (bits_pending),
        .o_bits_checked (bits_checked)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("[dcc_baseline_packet_generator] ERROR");
        $finish;
    end

    // Output side: random stalls, or a long hold-off when one has been requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            i_out_stall <= 1'b1;
            hold_left   <= LONG_HOLD;
            hold_served <= hold_requests;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic t_in_item make_req(input logic [1:0] mode, input logic [7:0] addr,
                                          input logic [9:0] thr);
        t_in_item req;
        req.mode           = mode;
        req.target_address = addr;
        req.throttle       = thr;
        return req;
    endfunction

    // Mostly throttle packets, many of them right at a range boundary.
    function automatic t_in_item random_request();
        t_in_item req;
        int pick;
        pick = $urandom_range(99);
        req.target_address = 8'($urandom_range(255));
        req.throttle       = 10'($urandom_range(1023));
        if (pick < 5)       req.mode = MODE_UNUSED;
        else if (pick < 17) req.mode = MODE_ESTOP;
        else if (pick < 30) req.mode = MODE_PROBE;
        else                req.mode = MODE_THROTTLE;
        case ($urandom_range(3))
            0: req.throttle = 10'(cur_reverse_limit + $urandom_range(2) - 1);
            1: req.throttle = 10'(cur_forward_start + $urandom_range(2) - 1);
            default: ;
        endcase
        return req;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item was taken.
    task automatic offer_item(input t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if (req.mode == MODE_UNUSED) ignored_count++;
        else                         packet_count++;
    endtask

    // A dropped request leaves no bits behind, so the drain time covers it.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (bits_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [9:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
    endtask

    task automatic write_settings(input logic [7:0] one_p, input logic [7:0] zero_p,
                                  input logic [9:0] rev_lim, input logic [9:0] fwd_start);
        wait_idle();
        write_reg(CFG_ONE_PERIOD, {2'b00, one_p});
        write_reg(CFG_ZERO_PERIOD, {2'b00, zero_p});
        write_reg(CFG_REVERSE_LIMIT, rev_lim);
        write_reg(CFG_FORWARD_START, fwd_start);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        cur_reverse_limit = rev_lim;
        cur_forward_start = fwd_start;
        settings_count++;
    endtask

    initial begin
        t_in_item req;
        int sent;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items at the reset settings.
        write_settings(ONE_PERIOD_RESET, ZERO_PERIOD_RESET, REVERSE_LIMIT_RESET,
                       FORWARD_START_RESET);
        offer_item(make_req(MODE_THROTTLE, 8'hFF, 10'd0));
        offer_item(make_req(MODE_THROTTLE, 8'h00, 10'd255));
        offer_item(make_req(MODE_THROTTLE, 8'hA5, 10'd256));
        offer_item(make_req(MODE_THROTTLE, 8'h5A, 10'd1023));
        offer_item(make_req(MODE_THROTTLE, 8'h3C, 10'd769));
        offer_item(make_req(MODE_THROTTLE, 8'hC3, 10'd768));
        offer_item(make_req(MODE_ESTOP, 8'hFF, 10'd1023));
        offer_item(make_req(MODE_PROBE, 8'h00, 10'd0));
        offer_item(make_req(MODE_PROBE, 8'hFF, 10'd512));
        offer_item(make_req(MODE_UNUSED, 8'hFF, 10'd1023));
        // The dead band keeps the forward direction set before the stop and probes.
        offer_item(make_req(MODE_THROTTLE, 8'h81, 10'd500));

        // Hold the output off while requests keep coming, so the input backs up.
        hold_requests <= hold_requests + 1;
        for (int k = 0; k < 6; k++) begin
            offer_item(make_req(MODE_THROTTLE, 8'(k * 40 + 1), 10'(k * 170)));
        end

        // Periods below range and limits overlapping over the whole scale.
        write_settings(8'd0, 8'd1, 10'd1023, 10'd0);
        offer_item(make_req(MODE_THROTTLE, 8'h12, 10'd1023));
        offer_item(make_req(MODE_THROTTLE, 8'h34, 10'd0));
        offer_item(make_req(MODE_ESTOP, 8'h56, 10'd7));

        write_settings(8'd255, 8'd255, 10'd0, 10'd0);
        offer_item(make_req(MODE_THROTTLE, 8'h01, 10'd0));
        offer_item(make_req(MODE_THROTTLE, 8'h02, 10'd1));
        offer_item(make_req(MODE_THROTTLE, 8'h80, 10'd1023));

        write_settings(8'd1, 8'd255, 10'd0, 10'd1023);
        offer_item(make_req(MODE_THROTTLE, 8'h7F, 10'd512));
        offer_item(make_req(MODE_THROTTLE, 8'hFE, 10'd1023));

        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            case (chunk)
                0: write_settings(ONE_PERIOD_RESET, ZERO_PERIOD_RESET, REVERSE_LIMIT_RESET,
                                  FORWARD_START_RESET);
                1: write_settings(8'd2, 8'd255, 10'd0, 10'd1023);
                2: write_settings(8'd255, 8'd2, 10'd600, 10'd400);
                3: write_settings(8'd1, 8'd0, 10'd1023, 10'd0);
                default: write_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                                        10'($urandom_range(1023)),
                                        10'($urandom_range(1023)));
            endcase
            if (chunk < 2) begin
                send_idle_pct = 19;
                recv_idle_pct <= 72;
            end else if (chunk < 4) begin
                send_idle_pct = 72;
                recv_idle_pct <= 19;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            sent = 0;
            while (sent < RANDOM_ITEMS / CHUNKS) begin
                req = random_request();
                offer_item(req);
                if (req.mode != MODE_UNUSED) sent++;
            end
        end

        wait_idle();
        $display("Sent %0d packet requests and %0d unused-mode requests under %0d settings,",
                 packet_count, ignored_count, settings_count);
        $display("with one long output hold-off; %0d serial bits were checked.", bits_checked);
        if (fail_count == 0 && bits_pending == 0) begin
            $display("[dcc_baseline_packet_generator] OK");
        end else begin
            $display("%0d failures, %0d bits still expected", fail_count, bits_pending);
            $display("[dcc_baseline_packet_generator] ERROR");
        end
        $finish;
    end

endmodule
